// ===== rtl/fce_pkg.sv =====
// Shared types and constants of the block-chain allocator.
package fce_pkg;

	// Link table geometry.
	localparam int unsigned TABLE_AW = 12;
	localparam int unsigned LINK_W   = 16;

	// Highest block index the table may ever hand out.
	localparam int unsigned MAX_BLOCKS = 4095;
	localparam logic [TABLE_AW-1:0] BLOCK_LIMIT =
		(MAX_BLOCKS > (2 ** TABLE_AW) - 1) ? TABLE_AW'((2 ** TABLE_AW) - 1)
		                                   : TABLE_AW'(MAX_BLOCKS);

	// Field widths.
	localparam int unsigned OP_W    = 2;
	localparam int unsigned BLOCK_W = 16;
	localparam int unsigned POS_W   = 24;
	localparam int unsigned ST_W    = 2;
	localparam int unsigned NB_W    = 12;
	localparam int unsigned CIDX_W  = 1;
	localparam int unsigned CDATA_W = 12;

	typedef logic [OP_W-1:0]    op_t;
	typedef logic [BLOCK_W-1:0] block_t;
	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [ST_W-1:0]    status_t;
	typedef logic [NB_W-1:0]    nblock_t;
	typedef logic [LINK_W-1:0]  link_t;

	// Link codes.
	localparam link_t LINK_FREE = 16'h0000;
	localparam link_t LINK_END  = 16'hFFFF;

	// Operation codes.
	localparam op_t OP_ALLOC = 2'd0;
	localparam op_t OP_SEEK  = 2'd1;
	localparam op_t OP_FREE  = 2'd2;
	localparam op_t OP_NONE  = 2'd3;

	// Status codes.
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_NOSPACE = 2'd1;
	localparam status_t ST_BROKEN  = 2'd2;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] CFG_BLOCK_SIZE_LOG2  = 1'b0;
	localparam logic [CIDX_W-1:0] CFG_DATA_BLOCK_COUNT = 1'b1;

	// Block size limits and reset values.
	localparam logic [3:0]  LG_MIN        = 4'd8;
	localparam logic [3:0]  LG_MAX        = 4'd12;
	localparam logic [3:0]  LG_RESET      = 4'd9;
	localparam logic [11:0] COUNT_RESET   = 12'd4095;

endpackage

// ===== rtl/fce_in_if.sv =====
// Request channel: one word per operation.
interface fce_in_if;
	logic                 valid;
	logic                 ready;
	fce_pkg::op_t         op;
	fce_pkg::block_t      block;
	fce_pkg::pos_t        position;
	fce_pkg::pos_t        offset;

	modport source (output valid, output op, output block, output position, output offset,
		input ready);
	modport sink (input valid, input op, input block, input position, input offset,
		output ready);
endinterface

// ===== rtl/fce_out_if.sv =====
// Response channel: one word per operation.
interface fce_out_if;
	logic                 valid;
	logic                 ready;
	fce_pkg::status_t     status;
	fce_pkg::nblock_t     alloc_block;
	fce_pkg::pos_t        new_position;

	modport source (output valid, output status, output alloc_block, output new_position,
		input ready);
	modport sink (input valid, input status, input alloc_block, input new_position,
		output ready);
endinterface

// ===== rtl/fce_cfg_if.sv =====
// Configuration write channel.
interface fce_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [fce_pkg::CIDX_W-1:0]        index;
	logic [fce_pkg::CDATA_W-1:0]       data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fat_chain_engine.sv =====
// Block-chain allocator over a 4096 x 16 link table held in one synchronous RAM.
// After reset the block runs a clearing pass over the table (one table entry a cycle)
// before it takes its first request; configuration writes are taken at any time.
// Every operation goes through the one RAM port pair, so its length is set by
// table accesses: allocate scans the table for the first free block, then writes the
// link (if a chain is extended) and the end mark; free reads and clears each chain
// entry in turn; seek reads one link per block boundary crossed (plus an allocation's
// scan and two writes where the chain is extended). A result sits in an output
// register, so the next request is taken while the previous result waits to be read.
module fat_chain_engine (
	input  logic        clk,
	input  logic        arst_n,
	fce_in_if.sink      req,
	fce_out_if.source   rsp,
	fce_cfg_if.sink     cfg
);

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_SCAN    = 4'd2;
	localparam logic [3:0] S_LINK    = 4'd3;
	localparam logic [3:0] S_MARK    = 4'd4;
	localparam logic [3:0] S_SEEK    = 4'd5;
	localparam logic [3:0] S_SEEK_RD = 4'd6;
	localparam logic [3:0] S_FREE    = 4'd7;
	localparam logic [3:0] S_FREE_WR = 4'd8;
	localparam logic [3:0] S_DONE    = 4'd9;

	localparam int unsigned AW = fce_pkg::TABLE_AW;
	localparam int unsigned RW = fce_pkg::POS_W + 1;

	// Link table RAM.
	fce_pkg::link_t mem [2**AW];
	fce_pkg::link_t rdata;
	logic           we;
	logic [AW-1:0]  waddr;
	logic [AW-1:0]  raddr;
	fce_pkg::link_t wdata;

	// Control registers.
	logic [3:0]  state_q, state_d;
	logic [AW-1:0] clr_q, clr_d;
	logic        pend_q, pend_d;
	logic        ov_q;
	logic [3:0]  bsl2_q;
	logic [11:0] dbc_q;

	// Working registers.
	logic [AW:0]           scan_q, scan_d;
	logic [AW-1:0]         pa_q, pa_d;
	logic [AW-1:0]         after_q, after_d;
	logic [AW-1:0]         found_q, found_d;
	fce_pkg::block_t       cur_q, cur_d;
	fce_pkg::block_t       blk_q, blk_d;
	logic [RW-1:0]         rem_q, rem_d;
	logic [3:0]            lg_q, lg_d;
	fce_pkg::op_t          op_q, op_d;
	fce_pkg::status_t      st_q, st_d;
	fce_pkg::nblock_t      nb_q, nb_d;
	fce_pkg::pos_t         np_q, np_d;

	// Result register.
	fce_pkg::status_t      out_st_q;
	fce_pkg::nblock_t      out_nb_q;
	fce_pkg::pos_t         out_np_q;

	// Decoded helpers.
	logic [AW-1:0]   cnt;
	logic [3:0]      lg_in;
	fce_pkg::pos_t   pos_mask;
	logic            acc;
	logic            slot_free;
	logic [RW-1:0]   bs;

	function automatic logic blk_valid(input fce_pkg::block_t b, input logic [AW-1:0] c);
		blk_valid = (b != '0) && (b <= fce_pkg::block_t'(c));
	endfunction

	assign cnt   = (dbc_q > fce_pkg::BLOCK_LIMIT) ? fce_pkg::BLOCK_LIMIT : dbc_q;
	assign lg_in = (bsl2_q < fce_pkg::LG_MIN) ? fce_pkg::LG_MIN :
	               (bsl2_q > fce_pkg::LG_MAX) ? fce_pkg::LG_MAX : bsl2_q;
	assign pos_mask  = ~(fce_pkg::pos_t'('1) << lg_in);
	assign bs        = RW'(1) << lg_q;
	assign acc       = req.valid && req.ready;
	assign slot_free = !ov_q || rsp.ready;

	assign req.ready        = (state_q == S_IDLE);
	assign cfg.ready        = 1'b1;
	assign rsp.valid        = ov_q;
	assign rsp.status       = out_st_q;
	assign rsp.alloc_block  = out_nb_q;
	assign rsp.new_position = out_np_q;

	// Table RAM: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

	// Sequencer: next state, RAM accesses and working values.
	always_comb begin
		state_d = state_q;
		clr_d   = clr_q;
		pend_d  = pend_q;
		scan_d  = scan_q;
		pa_d    = pa_q;
		after_d = after_q;
		found_d = found_q;
		cur_d   = cur_q;
		blk_d   = blk_q;
		rem_d   = rem_q;
		lg_d    = lg_q;
		op_d    = op_q;
		st_d    = st_q;
		nb_d    = nb_q;
		np_d    = np_q;
		we      = 1'b0;
		waddr   = clr_q;
		wdata   = fce_pkg::LINK_FREE;
		raddr   = scan_q[AW-1:0];

		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = (clr_q == AW'(1)) ? fce_pkg::LINK_END : fce_pkg::LINK_FREE;
				clr_d = clr_q + AW'(1);
				if (clr_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (acc) begin
					op_d   = req.op;
					st_d   = fce_pkg::ST_OK;
					nb_d   = '0;
					np_d   = '0;
					pend_d = 1'b0;
					scan_d = (AW+1)'(1);
					case (req.op)
						fce_pkg::OP_ALLOC: begin
							after_d = req.block[AW-1:0];
							if (req.block != '0 && !blk_valid(req.block, cnt)) begin
								st_d    = fce_pkg::ST_BROKEN;
								state_d = S_DONE;
							end else begin
								state_d = S_SCAN;
							end
						end
						fce_pkg::OP_SEEK: begin
							lg_d    = lg_in;
							cur_d   = fce_pkg::block_t'(req.position >> lg_in);
							rem_d   = RW'(req.position & pos_mask) + RW'(req.offset);
							state_d = S_SEEK;
						end
						fce_pkg::OP_FREE: begin
							blk_d   = req.block;
							state_d = S_FREE;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			// First-fit scan: one read issued per cycle, compared in the cycle after.
			S_SCAN: begin
				raddr = scan_q[AW-1:0];
				if (pend_q && rdata == fce_pkg::LINK_FREE) begin
					found_d = pa_q;
					pend_d  = 1'b0;
					state_d = (after_q != '0) ? S_LINK : S_MARK;
				end else if (scan_q <= {1'b0, cnt}) begin
					pend_d = 1'b1;
					pa_d   = scan_q[AW-1:0];
					scan_d = scan_q + (AW+1)'(1);
				end else begin
					pend_d  = 1'b0;
					st_d    = fce_pkg::ST_NOSPACE;
					state_d = S_DONE;
				end
			end
			S_LINK: begin
				we      = 1'b1;
				waddr   = after_q;
				wdata   = fce_pkg::link_t'(found_q);
				state_d = S_MARK;
			end
			// The end mark goes in last so that linking a block to itself ends the chain.
			S_MARK: begin
				we    = 1'b1;
				waddr = found_q;
				wdata = fce_pkg::LINK_END;
				if (op_q == fce_pkg::OP_SEEK) begin
					cur_d   = fce_pkg::block_t'(found_q);
					state_d = S_SEEK;
				end else begin
					nb_d    = fce_pkg::nblock_t'(found_q);
					state_d = S_DONE;
				end
			end
			// One block boundary per pass: check the block and fetch its link.
			S_SEEK: begin
				raddr = cur_q[AW-1:0];
				if ((rem_q >> lg_q) == '0) begin
					np_d    = fce_pkg::pos_t'(fce_pkg::pos_t'(cur_q) << lg_q)
					          + rem_q[fce_pkg::POS_W-1:0];
					state_d = S_DONE;
				end else if (!blk_valid(cur_q, cnt)) begin
					st_d    = fce_pkg::ST_BROKEN;
					state_d = S_DONE;
				end else begin
					rem_d   = rem_q - bs;
					state_d = S_SEEK_RD;
				end
			end
			S_SEEK_RD: begin
				if (rdata == fce_pkg::LINK_END) begin
					after_d = cur_q[AW-1:0];
					scan_d  = (AW+1)'(1);
					pend_d  = 1'b0;
					state_d = S_SCAN;
				end else if (blk_valid(rdata, cnt)) begin
					cur_d   = rdata;
					state_d = S_SEEK;
				end else begin
					st_d    = fce_pkg::ST_BROKEN;
					state_d = S_DONE;
				end
			end
			// Free walk: read the link, then clear the entry and follow it.
			S_FREE: begin
				raddr = blk_q[AW-1:0];
				if (blk_q == fce_pkg::LINK_END) begin
					state_d = S_DONE;
				end else if (!blk_valid(blk_q, cnt)) begin
					st_d    = fce_pkg::ST_BROKEN;
					state_d = S_DONE;
				end else begin
					state_d = S_FREE_WR;
				end
			end
			S_FREE_WR: begin
				we      = 1'b1;
				waddr   = blk_q[AW-1:0];
				wdata   = fce_pkg::LINK_FREE;
				blk_d   = rdata;
				state_d = S_FREE;
			end
			S_DONE: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			pend_q  <= 1'b0;
			ov_q    <= 1'b0;
			bsl2_q  <= fce_pkg::LG_RESET;
			dbc_q   <= fce_pkg::COUNT_RESET;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			pend_q  <= pend_d;
			if (state_q == S_DONE && slot_free) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			if (cfg.valid) begin
				unique case (cfg.index)
					fce_pkg::CFG_BLOCK_SIZE_LOG2:  bsl2_q <= cfg.data[3:0];
					fce_pkg::CFG_DATA_BLOCK_COUNT: dbc_q  <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	// Working and result payload registers.
	always_ff @(posedge clk) begin
		scan_q  <= scan_d;
		pa_q    <= pa_d;
		after_q <= after_d;
		found_q <= found_d;
		cur_q   <= cur_d;
		blk_q   <= blk_d;
		rem_q   <= rem_d;
		lg_q    <= lg_d;
		op_q    <= op_d;
		st_q    <= st_d;
		nb_q    <= nb_d;
		np_q    <= np_d;
		if (state_q == S_DONE && slot_free) begin
			out_st_q <= st_q;
			out_nb_q <= nb_q;
			out_np_q <= np_q;
		end
	end

endmodule

// ===== rtl/fce_checker.sv =====
// Port-level checks of the block-chain allocator and their binding.
module fce_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input fce_pkg::status_t     rsp_status,
	input fce_pkg::nblock_t     rsp_alloc_block,
	input fce_pkg::pos_t        rsp_new_position
);

	// A request is worked on alone: the request side closes right after a word is taken.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in progress");

	// A failed operation carries no block and no position.
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != fce_pkg::ST_OK |-> rsp_alloc_block == '0
			&& rsp_new_position == '0)
		else $error("failed operation returned a block or position");

	// An allocated block and a seek position never come in the same word.
	a_block_xor_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_alloc_block != '0 |-> rsp_new_position == '0)
		else $error("response carries both a block and a position");

	// A stalled response word holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_alloc_block) && $stable(rsp_new_position))
		else $error("stalled response changed");

endmodule

bind fat_chain_engine fce_checker u_fce_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_alloc_block  (rsp.alloc_block),
	.rsp_new_position (rsp.new_position)
);
